// ----- hdl/mbsg_pkg.sv -----
// Shared types and constants of the multi-axis step generator.
// Request and response payloads, request codes, status codes and controller states.
// No dependencies.
package mbsg_pkg;

  localparam int unsigned REQ_W     = 3;
  localparam int unsigned SLOT_IN_W = 4;
  localparam int unsigned AXIS_IN_W = 3;
  localparam int unsigned STEP_W    = 32;
  localparam int unsigned DIR_W     = 6;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned PER_W     = 16;
  localparam int unsigned SHIFT_W   = 2;
  localparam int unsigned ST_W      = 2;
  localparam int unsigned ACC_W     = STEP_W + 1;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK   = 3'd0,
    REQ_PUSH   = 3'd1,
    REQ_AXIS   = 3'd2,
    REQ_HEADER = 3'd3,
    REQ_START  = 3'd4,
    REQ_STOP   = 3'd5
  } req_type_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK         = 2'd0,
    ST_RING_FULL  = 2'd1,
    ST_ZERO_COUNT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CS_RUN = 2'd0,
    CS_SEG = 2'd1,
    CS_BLK = 2'd2
  } ctl_state_e;

  typedef struct packed {
    logic [REQ_W-1:0]     req_type;
    logic [SLOT_IN_W-1:0] block_slot;
    logic [AXIS_IN_W-1:0] axis_index;
    logic [STEP_W-1:0]    step_value;
    logic [DIR_W-1:0]     direction_in;
    logic [CNT_W-1:0]     seg_count;
    logic [PER_W-1:0]     seg_period;
    logic [SHIFT_W-1:0]   seg_shift;
  } mbsg_req_t;

  typedef struct packed {
    logic [DIR_W-1:0] step_pulses;
    logic [DIR_W-1:0] direction_out;
    logic [PER_W-1:0] period_out;
    logic             running;
    logic             segment_finished;
    logic [ST_W-1:0]  status;
  } mbsg_rsp_t;

  // Block header as stored per slot: event count and direction bits.
  typedef struct packed {
    logic [STEP_W-1:0] events;
    logic [DIR_W-1:0]  dirs;
  } hdr_t;

  localparam int unsigned HDR_W = $bits(hdr_t);

endpackage

// ----- hdl/multi_axis_bresenham_step_generator.sv -----
// Top level of the multi-axis Bresenham step generator.
// Depends on mbsg_pkg, mbsg_ram (segment ring, block headers, axis step counts)
// and mbsg_skid (response output stage).
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-----------
//   request | in        | req_valid_i / req_ready_o | req_i
//   response| out       | rsp_valid_o / rsp_ready_i | rsp_o
//
// Every request gives exactly one response. Writes, pushes, start, stop and
// ticks inside a running segment are taken back to back while the skid has room.
// A tick that has to load a new segment first reads the segment ring at the
// tail, then the block header and axis step RAMs at the segment's slot, and
// then does the load and the Bresenham step; no request is taken meanwhile.
// Reset clears pointers, counters and flags; the RAMs need no clearing pass.
// A stalled response parks in the skid stage; requests also stop once it fills.
module multi_axis_bresenham_step_generator
  import mbsg_pkg::*;
#(
  parameter int unsigned N_AXES      = 6,
  parameter int unsigned SEG_SLOTS   = 16,
  parameter int unsigned BLOCK_SLOTS = 16,
  parameter int unsigned MAX_SHIFT   = 3
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  input  mbsg_req_t req_i,
  output logic      rsp_valid_o,
  input  logic      rsp_ready_i,
  output mbsg_rsp_t rsp_o
);

  localparam int unsigned SegPtrW = $clog2(SEG_SLOTS);
  localparam int unsigned SegCntW = $clog2(SEG_SLOTS + 1);
  localparam int unsigned SlotW   = $clog2(BLOCK_SLOTS);
  localparam int unsigned WrapW   = (SlotW > SLOT_IN_W) ? SlotW + 1 : SLOT_IN_W + 1;

  typedef struct packed {
    logic [CNT_W-1:0]   count;
    logic [PER_W-1:0]   period;
    logic [SlotW-1:0]   slot;
    logic [SHIFT_W-1:0] shift;
  } ring_entry_t;

  localparam int unsigned RingW = $bits(ring_entry_t);

  // Fold the request's slot into the block store by repeated subtraction.
  function automatic logic [SlotW-1:0] wrap_slot(input logic [SLOT_IN_W-1:0] s);
    logic [WrapW-1:0] v;
    v = WrapW'(s);
    for (int i = 0; i < 8; i++) begin
      if (v >= WrapW'(BLOCK_SLOTS)) begin
        v = v - WrapW'(BLOCK_SLOTS);
      end
    end
    return SlotW'(v);
  endfunction

  // Clamp the smoothing shift to the deepest level supported.
  function automatic logic [SHIFT_W-1:0] sat_shift(input logic [SHIFT_W-1:0] s);
    if (32'(s) > MAX_SHIFT) begin
      return SHIFT_W'(MAX_SHIFT);
    end
    return s;
  endfunction

  // ------------------------------------------------------------------
  // Control and Bresenham state
  // ------------------------------------------------------------------
  ctl_state_e         state_q, state_d;
  logic [SegPtrW-1:0] head_q, head_d;
  logic [SegPtrW-1:0] tail_q, tail_d;
  logic [SegCntW-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0]   ticks_q, ticks_d;
  logic [SlotW-1:0]   active_q, active_d;
  logic               loaded_q, loaded_d;
  logic               seg_active_q, seg_active_d;
  logic               awake_q, awake_d;
  logic [DIR_W-1:0]   dir_q, dir_d;
  logic [PER_W-1:0]   period_q, period_d;
  logic [STEP_W-1:0]  ev_q, ev_d;
  logic [ACC_W-1:0]   accum_q [N_AXES];
  logic [ACC_W-1:0]   accum_d [N_AXES];
  logic [STEP_W-1:0]  incr_q [N_AXES];
  logic [STEP_W-1:0]  incr_d [N_AXES];

  logic             req_fire;
  logic [SlotW-1:0] slot_w;
  logic             ring_full;
  logic             ring_we, ring_re, hdr_we, blk_re;
  logic             step_en, load_en, new_block;
  logic             res_v, fin;
  logic [ST_W-1:0]  status;
  logic [CNT_W-1:0] tl_next;
  logic             skid_full;
  mbsg_rsp_t        res;

  logic [RingW-1:0]  ring_rdata;
  ring_entry_t       seg_rd, seg_wr;
  logic [HDR_W-1:0]  hdr_rdata;
  hdr_t              hdr_rd, hdr_wr;
  logic [STEP_W-1:0] axis_rd [N_AXES];
  logic [N_AXES-1:0] axis_we;
  logic [N_AXES-1:0] step_v;
  logic [DIR_W-1:0]  pulses;
  logic [ACC_W-1:0]  ev_use;

  assign req_ready_o = (state_q == CS_RUN) && !skid_full;
  assign req_fire    = req_valid_i && req_ready_o;
  assign slot_w      = wrap_slot(req_i.block_slot);
  assign ring_full   = cnt_q >= SegCntW'(SEG_SLOTS);

  assign seg_rd = ring_entry_t'(ring_rdata);
  assign hdr_rd = hdr_t'(hdr_rdata);

  assign seg_wr.count  = req_i.seg_count;
  assign seg_wr.period = req_i.seg_period;
  assign seg_wr.slot   = slot_w;
  assign seg_wr.shift  = sat_shift(req_i.seg_shift);

  assign hdr_wr.events = req_i.step_value;
  assign hdr_wr.dirs   = req_i.direction_in;

  // ------------------------------------------------------------------
  // Storage: segment ring, block headers, one step-count RAM per axis
  // ------------------------------------------------------------------
  mbsg_ram #(
    .WIDTH (RingW),
    .DEPTH (SEG_SLOTS)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (head_q),
    .wdata_i (RingW'(seg_wr)),
    .re_i    (ring_re),
    .raddr_i (tail_q),
    .rdata_o (ring_rdata)
  );

  mbsg_ram #(
    .WIDTH (HDR_W),
    .DEPTH (BLOCK_SLOTS)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (hdr_we),
    .waddr_i (slot_w),
    .wdata_i (HDR_W'(hdr_wr)),
    .re_i    (blk_re),
    .raddr_i (seg_rd.slot),
    .rdata_o (hdr_rdata)
  );

  // Reload the event count at load time; otherwise use the cached copy.
  assign ev_use    = load_en ? ACC_W'(hdr_rd.events) : ACC_W'(ev_q);
  assign new_block = !loaded_q || (active_q != seg_rd.slot);
  assign tl_next   = (load_en ? seg_rd.count : ticks_q) - CNT_W'(1);

  for (genvar a = 0; a < N_AXES; a++) begin : g_axis
    logic [ACC_W-1:0] acc_base;
    logic [ACC_W-1:0] sum;

    assign axis_we[a] = req_fire && (req_i.req_type == REQ_AXIS)
                        && (req_i.axis_index == AXIS_IN_W'(a));

    mbsg_ram #(
      .WIDTH (STEP_W),
      .DEPTH (BLOCK_SLOTS)
    ) u_axis_ram (
      .clk_i   (clk_i),
      .we_i    (axis_we[a]),
      .waddr_i (slot_w),
      .wdata_i (req_i.step_value),
      .re_i    (blk_re),
      .raddr_i (seg_rd.slot),
      .rdata_o (axis_rd[a])
    );

    // A new block restarts the counter at half the event count.
    assign incr_d[a] = load_en ? (axis_rd[a] >> seg_rd.shift) : incr_q[a];
    assign acc_base  = (load_en && new_block) ? (ACC_W'(hdr_rd.events) >> 1) : accum_q[a];
    assign sum       = acc_base + ACC_W'(incr_d[a]);
    assign step_v[a] = sum > ev_use;
    assign accum_d[a] = step_v[a] ? (sum - ev_use) : sum;
  end

  for (genvar i = 0; i < DIR_W; i++) begin : g_pulse
    if (i < N_AXES) begin : g_on
      assign pulses[i] = step_v[i];
    end else begin : g_off
      assign pulses[i] = 1'b0;
    end
  end

  // ------------------------------------------------------------------
  // Request decode and segment load sequencer
  // ------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    cnt_d        = cnt_q;
    ticks_d      = ticks_q;
    active_d     = active_q;
    loaded_d     = loaded_q;
    seg_active_d = seg_active_q;
    awake_d      = awake_q;
    dir_d        = dir_q;
    period_d     = period_q;
    ev_d         = ev_q;
    ring_we      = 1'b0;
    ring_re      = 1'b0;
    hdr_we       = 1'b0;
    blk_re       = 1'b0;
    step_en      = 1'b0;
    load_en      = 1'b0;
    res_v        = 1'b0;
    fin          = 1'b0;
    status       = ST_OK;

    unique case (state_q)
      CS_RUN: begin
        if (req_fire) begin
          res_v = 1'b1;
          unique case (req_i.req_type)
            REQ_TICK: begin
              if (awake_q) begin
                if (seg_active_q) begin
                  step_en = 1'b1;
                end else if (cnt_q == '0) begin
                  awake_d = 1'b0;
                end else begin
                  // Hold the response until the segment and its block are read.
                  ring_re = 1'b1;
                  res_v   = 1'b0;
                  state_d = CS_SEG;
                end
              end
            end
            REQ_PUSH: begin
              if (req_i.seg_count == '0) begin
                status = ST_ZERO_COUNT;
              end else if (ring_full) begin
                status = ST_RING_FULL;
              end else begin
                ring_we = 1'b1;
                head_d  = (head_q == SegPtrW'(SEG_SLOTS - 1)) ? '0 : head_q + SegPtrW'(1);
                cnt_d   = cnt_q + SegCntW'(1);
              end
            end
            REQ_AXIS: begin
            end
            REQ_HEADER: begin
              hdr_we = 1'b1;
              // Forward a new event count of the executing block to the cache.
              if (slot_w == active_q) begin
                ev_d = req_i.step_value;
              end
            end
            REQ_START: begin
              awake_d = 1'b1;
            end
            REQ_STOP: begin
              awake_d = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      CS_SEG: begin
        blk_re  = 1'b1;
        state_d = CS_BLK;
      end
      CS_BLK: begin
        step_en  = 1'b1;
        load_en  = 1'b1;
        res_v    = 1'b1;
        state_d  = CS_RUN;
        loaded_d = 1'b1;
        active_d = seg_rd.slot;
        dir_d    = hdr_rd.dirs;
        period_d = seg_rd.period;
        ev_d     = hdr_rd.events;
      end
      default: begin
        state_d = CS_RUN;
      end
    endcase

    // Advance the segment; pop it from the ring once its ticks are spent.
    if (step_en) begin
      ticks_d = tl_next;
      if (tl_next == '0) begin
        seg_active_d = 1'b0;
        tail_d       = (tail_q == SegPtrW'(SEG_SLOTS - 1)) ? '0 : tail_q + SegPtrW'(1);
        cnt_d        = cnt_q - SegCntW'(1);
        fin          = 1'b1;
      end else begin
        seg_active_d = 1'b1;
      end
    end

    res.step_pulses      = step_en ? pulses : '0;
    res.direction_out    = dir_d;
    res.period_out       = period_d;
    res.running          = awake_d;
    res.segment_finished = fin;
    res.status           = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= CS_RUN;
      head_q       <= '0;
      tail_q       <= '0;
      cnt_q        <= '0;
      ticks_q      <= '0;
      active_q     <= '0;
      loaded_q     <= 1'b0;
      seg_active_q <= 1'b0;
      awake_q      <= 1'b0;
      dir_q        <= '0;
      period_q     <= '0;
      ev_q         <= '0;
      for (int a = 0; a < N_AXES; a++) begin
        accum_q[a] <= '0;
        incr_q[a]  <= '0;
      end
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      cnt_q        <= cnt_d;
      ticks_q      <= ticks_d;
      active_q     <= active_d;
      loaded_q     <= loaded_d;
      seg_active_q <= seg_active_d;
      awake_q      <= awake_d;
      dir_q        <= dir_d;
      period_q     <= period_d;
      ev_q         <= ev_d;
      for (int a = 0; a < N_AXES; a++) begin
        if (step_en) begin
          accum_q[a] <= accum_d[a];
        end
        incr_q[a] <= incr_d[a];
      end
    end
  end

  // ------------------------------------------------------------------
  // Response stage
  // ------------------------------------------------------------------
  mbsg_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_v),
    .in_data_i   (res),
    .full_o      (skid_full),
    .out_valid_o (rsp_valid_o),
    .out_ready_i (rsp_ready_i),
    .out_data_o  (rsp_o)
  );

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_ring_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= SegCntW'(SEG_SLOTS))
    else $error("segment ring count above capacity");

  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |-> (cnt_q != '0))
    else $error("segment popped from an empty ring");

  a_seg_then_blk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CS_SEG) |=> (state_q == CS_BLK))
    else $error("segment load sequence broken");

  a_active_loaded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_active_q |-> loaded_q)
    else $error("segment executing without a loaded block");

  a_no_skid_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v |-> !skid_full)
    else $error("response produced while skid stage is occupied");

endmodule

// ----- hdl/mbsg_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mbsg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/mbsg_skid.sv -----
// Response output register with a one-entry skid stage behind it.
// Depends on mbsg_pkg for the response type.
module mbsg_skid
  import mbsg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  mbsg_rsp_t in_data_i,
  output logic      full_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output mbsg_rsp_t out_data_o
);

  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  mbsg_rsp_t out_data_q, out_data_d;
  mbsg_rsp_t skid_data_q, skid_data_d;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (out_valid_q && out_ready_i) begin
      // Refill from skid first, then from the incoming response.
      if (skid_valid_q) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = in_valid_i;
        out_data_d  = in_data_i;
      end
    end else if (!out_valid_q) begin
      out_valid_d = in_valid_i;
      out_data_d  = in_data_i;
    end else if (in_valid_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the multi-axis Bresenham step generator.
// Drives random request streams with idling and checks every response against
// an in-bench engine model. Depends on mbsg_pkg and the RTL top level only.
module tb_top;
  import mbsg_pkg::*;

  localparam int unsigned AXES        = 6;
  localparam int unsigned RING_SLOTS  = 16;
  localparam int unsigned BLOCK_CNT   = 16;
  localparam int unsigned RANDOM_REQS = 1650;
  localparam int unsigned HOLD_CYCLES = 120;
  localparam int unsigned TAIL_REQS   = 150;
  localparam int unsigned DRAIN_WAIT  = 20;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PRINT_CAP   = 50;

  // Request codes the block treats as no-ops.
  localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

  // One ring entry as the engine keeps it.
  typedef struct packed {
    logic [CNT_W-1:0]     count;
    logic [PER_W-1:0]     period;
    logic [SLOT_IN_W-1:0] slot;
    logic [SHIFT_W-1:0]   shift;
  } seg_rec_t;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      req_valid_i;
  logic      req_ready_o;
  mbsg_req_t req_i;
  logic      rsp_valid_o;
  logic      rsp_ready_i;
  mbsg_rsp_t rsp_o;

  multi_axis_bresenham_step_generator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_ready_i(rsp_ready_i),
    .rsp_o      (rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Engine state as the bench tracks it. Every store starts at zero; the
  // stimulus never lets a segment name a block slot that was not fully written.
  // ---------------------------------------------------------------------------
  seg_rec_t          ring_mem    [RING_SLOTS]           = '{default: '0};
  logic [3:0]        ring_rd     = '0;
  logic [3:0]        ring_wr     = '0;
  int unsigned       ring_fill   = 0;
  logic [STEP_W-1:0] slot_steps  [BLOCK_CNT][AXES]      = '{default: '{default: '0}};
  logic [STEP_W-1:0] slot_events [BLOCK_CNT]            = '{default: '0};
  logic [DIR_W-1:0]  slot_dirs   [BLOCK_CNT]            = '{default: '0};
  logic [ACC_W-1:0]  axis_acc    [AXES]                 = '{default: '0};
  logic [STEP_W-1:0] axis_inc    [AXES]                 = '{default: '0};
  logic [CNT_W-1:0]  ticks_rem   = '0;
  logic [3:0]        cur_blk     = '0;
  bit                blk_valid   = 1'b0;
  bit                seg_busy    = 1'b0;
  bit                awake       = 1'b0;
  logic [DIR_W-1:0]  cur_dirs    = '0;
  logic [PER_W-1:0]  cur_per     = '0;

  // Requests waiting to be driven, and responses owed by the block.
  mbsg_req_t pending_requests[$];
  mbsg_rsp_t due_responses[$];

  // Block slots whose header and all axis counts have been written.
  bit slot_ready [BLOCK_CNT] = '{default: 1'b0};

  int unsigned req_count   = 0;
  int unsigned req_accepts = 0;
  int unsigned rsp_seen    = 0;
  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;
  int unsigned n_ticks     = 0;
  int unsigned n_pushes    = 0;
  int unsigned n_finished  = 0;
  int unsigned n_full      = 0;
  int unsigned n_zero      = 0;
  int unsigned n_pulses    = 0;
  bit          timed_out   = 1'b0;
  bit          hold_off    = 1'b0;
  bit          req_fired;
  int unsigned tx_gap      = 0;
  int unsigned rx_gap      = 0;
  int unsigned tx_level    = 1;
  int unsigned rx_level    = 1;
  mbsg_rsp_t   next_rsp;

  // ---------------------------------------------------------------------------
  // Engine model: apply one request, return the response it must produce.
  // ---------------------------------------------------------------------------
  function automatic mbsg_rsp_t engine_response(mbsg_req_t r);
    mbsg_rsp_t        o;
    seg_rec_t         s;
    logic [ACC_W-1:0] ev;
    logic [ACC_W-1:0] sum;
    int               a;
    o = '0;
    case (r.req_type)
      REQ_TICK: begin
        if (awake) begin
          if (!seg_busy && ring_fill == 0) begin
            // Nothing left to run: fall asleep, no step.
            awake = 1'b0;
          end else begin
            if (!seg_busy) begin
              s = ring_mem[ring_rd];
              cur_per   = s.period;
              ticks_rem = s.count;
              // Restart the counters only on the first block or a block change.
              if (!blk_valid || cur_blk != s.slot) begin
                cur_blk   = s.slot;
                blk_valid = 1'b1;
                for (a = 0; a < AXES; a++) axis_acc[a] = ACC_W'(slot_events[cur_blk] >> 1);
              end
              cur_dirs = slot_dirs[cur_blk];
              // Shift field is 2 bits wide, so it never exceeds the maximum.
              for (a = 0; a < AXES; a++) axis_inc[a] = slot_steps[cur_blk][a] >> s.shift;
              seg_busy = 1'b1;
            end
            // Event count is read live, so a header rewrite acts on this tick.
            ev = ACC_W'(slot_events[cur_blk]);
            for (a = 0; a < AXES; a++) begin
              sum = axis_acc[a] + ACC_W'(axis_inc[a]);
              if (sum > ev) begin
                o.step_pulses[a] = 1'b1;
                sum = sum - ev;
              end
              axis_acc[a] = sum;
            end
            ticks_rem = ticks_rem - 1'b1;
            if (ticks_rem == 0) begin
              seg_busy  = 1'b0;
              ring_rd   = ring_rd + 1'b1;
              ring_fill = ring_fill - 1;
              o.segment_finished = 1'b1;
            end
          end
        end
      end
      REQ_PUSH: begin
        if (r.seg_count == 0) begin
          o.status = ST_ZERO_COUNT;
        end else if (ring_fill >= RING_SLOTS) begin
          o.status = ST_RING_FULL;
        end else begin
          s.count  = r.seg_count;
          s.period = r.seg_period;
          s.slot   = r.block_slot;
          s.shift  = r.seg_shift;
          ring_mem[ring_wr] = s;
          ring_wr   = ring_wr + 1'b1;
          ring_fill = ring_fill + 1;
        end
      end
      REQ_AXIS: begin
        if (r.axis_index < AXES) slot_steps[r.block_slot][r.axis_index] = r.step_value;
      end
      REQ_HEADER: begin
        slot_events[r.block_slot] = r.step_value;
        slot_dirs[r.block_slot]   = r.direction_in;
      end
      REQ_START: awake = 1'b1;
      REQ_STOP:  awake = 1'b0;
      default: ;
    endcase
    o.direction_out = cur_dirs;
    o.period_out    = cur_per;
    o.running       = awake;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Request builders. Fields a request does not use carry random noise.
  // ---------------------------------------------------------------------------
  function automatic mbsg_req_t noise_req();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(mbsg_req_t)-1:0];
  endfunction

  task automatic add_req(mbsg_req_t r);
    pending_requests.push_back(r);
    if (r.req_type <= REQ_STOP) req_count++;
  endtask

  task automatic put_op(logic [REQ_W-1:0] code);
    mbsg_req_t r;
    r = noise_req();
    r.req_type = code;
    add_req(r);
  endtask

  task automatic put_ticks(int unsigned n);
    repeat (n) put_op(REQ_TICK);
  endtask

  task automatic put_header(logic [3:0] slot, logic [31:0] ev, logic [5:0] dirs);
    mbsg_req_t r;
    r = noise_req();
    r.req_type     = REQ_HEADER;
    r.block_slot   = slot;
    r.step_value   = ev;
    r.direction_in = dirs;
    add_req(r);
  endtask

  task automatic put_axis(logic [3:0] slot, logic [2:0] axis, logic [31:0] val);
    mbsg_req_t r;
    r = noise_req();
    r.req_type   = REQ_AXIS;
    r.block_slot = slot;
    r.axis_index = axis;
    r.step_value = val;
    add_req(r);
  endtask

  task automatic put_push(logic [3:0] slot, logic [15:0] cnt, logic [15:0] per,
                          logic [1:0] sh);
    mbsg_req_t r;
    r = noise_req();
    r.req_type   = REQ_PUSH;
    r.block_slot = slot;
    r.seg_count  = cnt;
    r.seg_period = per;
    r.seg_shift  = sh;
    add_req(r);
  endtask

  function automatic logic [31:0] pick_events();
    case ($urandom_range(0, 6))
      0: return $urandom_range(1, 16);
      1: return $urandom_range(1, 64);
      2: return $urandom_range(64, 5000);
      3: return $urandom;
      4: return '0;
      5: return 32'hFFFF_FFFF;
      default: return $urandom_range(1, 1000);
    endcase
  endfunction

  // Mostly steps within the event count; sometimes above it to wrap counters.
  function automatic logic [31:0] pick_steps(logic [31:0] ev);
    case ($urandom_range(0, 9))
      7: return $urandom;
      8: return ev;
      9: return '0;
      default: return $urandom_range(ev, 0);
    endcase
  endfunction

  function automatic logic [15:0] pick_count();
    case ($urandom_range(0, 19))
      0: return CNT_W'($urandom_range(41, 120));
      1, 2, 3: return CNT_W'($urandom_range(9, 40));
      default: return CNT_W'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [15:0] pick_period();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 16'hFFFF;
      default: return PER_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [3:0] pick_ready_slot();
    logic [3:0] s;
    s = SLOT_IN_W'($urandom_range(0, BLOCK_CNT - 1));
    while (!slot_ready[s]) s = SLOT_IN_W'($urandom_range(0, BLOCK_CNT - 1));
    return s;
  endfunction

  task automatic write_slot(logic [3:0] slot);
    logic [31:0] ev;
    ev = pick_events();
    put_header(slot, ev, DIR_W'($urandom));
    for (int a = 0; a < AXES; a++) put_axis(slot, AXIS_IN_W'(a), pick_steps(ev));
    slot_ready[slot] = 1'b1;
  endtask

  task automatic flag_mismatch(string msg);
    if (err_count < PRINT_CAP) $display("MISMATCH: %s", msg);
    err_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      flag_mismatch($sformatf("response %0d %s got 0x%0h want 0x%0h",
                              rsp_seen, name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus: directed opening, then random sequences, then wait for the drain.
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] slot0_steps  [AXES];
    logic [31:0] slot15_steps [AXES];
    int unsigned base;
    int unsigned kind;
    int unsigned segs;
    int unsigned left;
    int unsigned chunk;
    logic [3:0]  home;
    logic [15:0] cnt;
    mbsg_req_t   r;

    rst_ni      = 1'b0;
    req_valid_i = 1'b0;
    req_i       = '0;
    rsp_ready_i = 1'b0;

    // Directed opening: block slots at both ends with extreme counts.
    slot0_steps  = '{32'd0, 32'd100, 32'd50, 32'd33, 32'hFFFF_FFFF, 32'd1};
    slot15_steps = '{32'hFFFF_FFFF, 32'h8000_0000, 32'd0, 32'd1, 32'h7FFF_FFFF,
                     32'h5555_5555};
    put_header(4'd0, 32'd100, 6'b101010);
    for (int a = 0; a < AXES; a++) put_axis(4'd0, AXIS_IN_W'(a), slot0_steps[a]);
    // Axis indexes past the last axis must be dropped.
    put_axis(4'd0, 3'd6, $urandom);
    put_axis(4'd0, 3'd7, $urandom);
    put_header(4'd15, 32'hFFFF_FFFF, 6'b010101);
    for (int a = 0; a < AXES; a++) put_axis(4'd15, AXIS_IN_W'(a), slot15_steps[a]);
    slot_ready[0]  = 1'b1;
    slot_ready[15] = 1'b1;
    put_op(REQ_TICK);                      // tick while asleep
    put_op(REQ_START);
    put_op(REQ_TICK);                      // empty ring puts it back to sleep
    put_push(4'd0, 16'd0, 16'hFFFF, 2'd1); // zero count rejected
    put_push(4'd0, 16'd3, 16'hFFFF, 2'd0);
    put_push(4'd15, 16'd2, 16'd0, 2'd3);
    put_push(4'd0, 16'd1, 16'h1234, 2'd2);
    put_op(REQ_START);
    put_ticks(2);
    put_op(REQ_STOP);                      // stop keeps the running segment
    put_op(REQ_TICK);
    put_op(REQ_START);
    put_ticks(5);
    put_op(REQ_SPARE_6);
    put_op(REQ_SPARE_7);

    // Random part: mostly well-formed motion sequences.
    base = req_count;
    while (req_count - base < RANDOM_REQS) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        if ($urandom_range(0, 9) < 3)
          write_slot(SLOT_IN_W'($urandom_range(0, BLOCK_CNT - 1)));
        home = pick_ready_slot();
        segs = $urandom_range(1, 5);
        left = 0;
        for (int i = 0; i < segs; i++) begin
          cnt = pick_count();
          put_push(($urandom_range(0, 9) < 7) ? home : pick_ready_slot(), cnt,
                   pick_period(), SHIFT_W'($urandom));
          left += 32'(cnt);
        end
        put_op(REQ_START);
        left += $urandom_range(0, 3);
        while (left > 0) begin
          chunk = $urandom_range(1, left);
          put_ticks(chunk);
          left -= chunk;
          if (left > 0) begin
            case ($urandom_range(0, 9))
              0: begin
                put_op(REQ_STOP);
                put_ticks($urandom_range(1, 2));
                put_op(REQ_START);
              end
              1: put_header(home, pick_events(), DIR_W'($urandom));
              2: begin
                cnt = pick_count();
                put_push(pick_ready_slot(), cnt, pick_period(), SHIFT_W'($urandom));
                left += 32'(cnt);
              end
              default: ;
            endcase
          end
        end
      end else if (kind < 75) begin
        // Push 14 to 20 segments while stopped, often overfilling the ring, then drain it.
        put_op(REQ_STOP);
        segs = $urandom_range(14, 20);
        left = 0;
        for (int i = 0; i < segs; i++) begin
          cnt = CNT_W'($urandom_range(1, 4));
          put_push(pick_ready_slot(), cnt, pick_period(), SHIFT_W'($urandom));
          left += 32'(cnt);
        end
        put_op(REQ_START);
        put_ticks(left + $urandom_range(0, 4));
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 4)) begin
          r = noise_req();
          r.req_type = REQ_W'($urandom_range(0, 7));
          if (r.req_type == REQ_PUSH) begin
            r.block_slot = pick_ready_slot();
            r.seg_count  = CNT_W'($urandom_range(0, 6));
          end
          add_req(r);
        end
      end else if (kind < 90) begin
        put_push(SLOT_IN_W'($urandom), 16'd0, pick_period(), SHIFT_W'($urandom));
      end else begin
        put_op(REQ_STOP);
        put_ticks($urandom_range(1, 3));
        put_op(REQ_START);
        put_ticks($urandom_range(1, 2));
      end
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every request to go in and every response to come back.
    while (!(pending_requests.size() == 0 && !req_valid_i && due_responses.size() == 0)
           && !timed_out)
      @(negedge clk_i);
    if (!timed_out) repeat (DRAIN_WAIT) @(posedge clk_i);

    if (timed_out)
      flag_mismatch($sformatf("timeout after %0d cycles", cycle_count));
    if (due_responses.size() != 0)
      flag_mismatch($sformatf("%0d responses never arrived", due_responses.size()));

    $display("Covered %0d requests: %0d ticks, %0d pushes, %0d segments finished, %0d pulses",
             req_accepts, n_ticks, n_pushes, n_finished, n_pulses);
    $display("Ring-full drops %0d, zero-count rejects %0d, mismatches %0d",
             n_full, n_zero, err_count);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Request driver: change inputs on the falling edge, hold a request until
  // it is taken, idle in short bursts unless a hold-off or the tail is on.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!req_valid_i || req_fired) begin
        if (tx_gap == 0 && !hold_off && pending_requests.size() > TAIL_REQS &&
            $urandom_range(0, 15) < tx_level * 2)
          tx_gap = $urandom_range(1, 5);
        if (tx_gap > 0) begin
          tx_gap--;
          req_valid_i <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          req_i       <= pending_requests.pop_front();
          req_valid_i <= 1'b1;
        end else begin
          req_valid_i <= 1'b0;
        end
      end
    end
  end

  // Response side: drop ready in bursts, or for the whole hold-off.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_off) begin
        rsp_ready_i <= 1'b0;
      end else begin
        if (rx_gap == 0 && pending_requests.size() > TAIL_REQS &&
            $urandom_range(0, 15) < rx_level * 2)
          rx_gap = $urandom_range(1, 5);
        if (rx_gap > 0) begin
          rx_gap--;
          rsp_ready_i <= 1'b0;
        end else begin
          rsp_ready_i <= 1'b1;
        end
      end
    end
  end

  // Hold off the response side twice for a long stretch so the block backs up
  // and stalls its request input while the driver keeps offering.
  initial begin
    wait (rst_ni === 1'b1);
    while (req_accepts < 300) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off = 1'b0;
    while (req_accepts < 1100) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Monitor: on each rising edge, model an accepted request first, then check
  // an accepted response against the oldest one owed.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_fired <= 1'b0;
    end else begin
      req_fired <= req_valid_i && req_ready_o;
      if (req_valid_i && req_ready_o) begin
        next_rsp = engine_response(req_i);
        due_responses.push_back(next_rsp);
        req_accepts++;
        if (req_i.req_type == REQ_TICK) n_ticks++;
        if (req_i.req_type == REQ_PUSH) n_pushes++;
        if (next_rsp.segment_finished) n_finished++;
        if (next_rsp.step_pulses != 0) n_pulses++;
        if (next_rsp.status == ST_RING_FULL) n_full++;
        if (next_rsp.status == ST_ZERO_COUNT) n_zero++;
      end
      if (rsp_valid_o && rsp_ready_i) begin
        rsp_seen++;
        if (due_responses.size() == 0) begin
          flag_mismatch($sformatf("response %0d arrived with none owed", rsp_seen));
        end else begin
          next_rsp = due_responses.pop_front();
          check_field("step_pulses", 32'(rsp_o.step_pulses), 32'(next_rsp.step_pulses));
          check_field("direction_out", 32'(rsp_o.direction_out),
                      32'(next_rsp.direction_out));
          check_field("period_out", 32'(rsp_o.period_out), 32'(next_rsp.period_out));
          check_field("running", 32'(rsp_o.running), 32'(next_rsp.running));
          check_field("segment_finished", 32'(rsp_o.segment_finished),
                      32'(next_rsp.segment_finished));
          check_field("status", 32'(rsp_o.status), 32'(next_rsp.status));
        end
      end
    end
  end

  // Cycle count, idle intensity per stretch (level 0 means no idling), watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count % 128 == 0) begin
      tx_level = $urandom_range(0, 3);
      rx_level = $urandom_range(0, 3);
    end
    if (cycle_count >= CYCLE_LIMIT) timed_out = 1'b1;
  end

endmodule
